// ===== sv/sgm_pkg.sv =====
// Shared types and constants for the Sobel gradient magnitude core.
// Used by the raster controller, the window datapath and the top level.
`default_nettype none

package sgm_pkg;

    localparam int PIXEL_W        = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int ROW_W          = 12;
    // Width used when clamping the frame dimensions; holds every legal line length.
    localparam int DIM_W          = 13;
    localparam int MIN_DIM        = 3;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int RESET_DIM      = 1024;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int SUM_W          = 10;
    localparam int GRAD_W         = 11;
    localparam int MAG_W          = 11;
    localparam int MAG_MAX        = 255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    // Position of a request within the frame, worked out when it is accepted.
    typedef struct packed {
        logic interior;
        logic frame_last;
    } pos_flags_t;

endpackage

`default_nettype wire

// ===== sv/sgm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the line stores of the Sobel core.
`default_nettype none

module sgm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/sgm_raster_ctrl.sv =====
// Frame geometry registers and raster position counters of the Sobel core.
// Depends on sgm_pkg for widths, register indexes and the position flags type.
`default_nettype none

module sgm_raster_ctrl #(
    parameter int MAX_LINE = 1024,
    localparam int ADDR_W = $clog2(MAX_LINE)
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                pix_accept,
    input  wire logic                                cfg_write,
    input  wire logic [sgm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [sgm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic      [ADDR_W-1:0]                   col_addr,
    output sgm_pkg::pos_flags_t                      pos_flags
);

    localparam logic [sgm_pkg::DIM_W-1:0] MAX_LINE_D = sgm_pkg::DIM_W'(MAX_LINE);
    localparam logic [sgm_pkg::DIM_W-1:0] MIN_D      = sgm_pkg::DIM_W'(sgm_pkg::MIN_DIM);
    localparam logic [sgm_pkg::DIM_W-1:0] HEIGHT_D   = sgm_pkg::DIM_W'(sgm_pkg::HEIGHT_LIMIT);
    localparam logic [sgm_pkg::DIM_W-1:0] ONE_D      = sgm_pkg::DIM_W'(1);

    logic [sgm_pkg::FRAME_WIDTH_W-1:0]  frame_width_reg,  frame_width_next;
    logic [sgm_pkg::FRAME_HEIGHT_W-1:0] frame_height_reg, frame_height_next;
    logic [ADDR_W-1:0]                  col_count_reg,    col_count_next;
    logic [sgm_pkg::ROW_W-1:0]          row_count_reg,    row_count_next;

    logic [sgm_pkg::DIM_W-1:0] width_ext, height_ext;
    logic [sgm_pkg::DIM_W-1:0] width_use, height_use;
    logic [ADDR_W-1:0]         col_last;
    logic [sgm_pkg::ROW_W-1:0] row_last;
    logic                      cfg_hit;

    assign width_ext  = sgm_pkg::DIM_W'(frame_width_reg);
    assign height_ext = sgm_pkg::DIM_W'(frame_height_reg);

    always_comb begin
        priority if (width_ext < MIN_D) begin
            width_use = MIN_D;
        end else if (width_ext > MAX_LINE_D) begin
            width_use = MAX_LINE_D;
        end else begin
            width_use = width_ext;
        end

        priority if (height_ext < MIN_D) begin
            height_use = MIN_D;
        end else if (height_ext > HEIGHT_D) begin
            height_use = HEIGHT_D;
        end else begin
            height_use = height_ext;
        end
    end

    assign col_last = ADDR_W'(width_use - ONE_D);
    assign row_last = sgm_pkg::ROW_W'(height_use - ONE_D);

    assign cfg_hit = cfg_write && ((cfg_index == sgm_pkg::REG_FRAME_WIDTH) ||
                                   (cfg_index == sgm_pkg::REG_FRAME_HEIGHT));

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        col_count_next    = col_count_reg;
        row_count_next    = row_count_reg;

        if (cfg_write && (cfg_index == sgm_pkg::REG_FRAME_WIDTH)) begin
            frame_width_next = cfg_data[sgm_pkg::FRAME_WIDTH_W-1:0];
        end
        if (cfg_write && (cfg_index == sgm_pkg::REG_FRAME_HEIGHT)) begin
            frame_height_next = cfg_data[sgm_pkg::FRAME_HEIGHT_W-1:0];
        end

        // A write to frame_width or frame_height restarts the frame at its first pixel.
        if (cfg_hit) begin
            col_count_next = '0;
            row_count_next = '0;
        end else if (pix_accept) begin
            if (col_count_reg == col_last) begin
                col_count_next = '0;
                row_count_next = (row_count_reg == row_last) ? '0
                               : row_count_reg + sgm_pkg::ROW_W'(1);
            end else begin
                col_count_next = col_count_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= sgm_pkg::FRAME_WIDTH_W'(sgm_pkg::RESET_DIM);
            frame_height_reg <= sgm_pkg::FRAME_HEIGHT_W'(sgm_pkg::RESET_DIM);
            col_count_reg    <= '0;
            row_count_reg    <= '0;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_count_reg    <= col_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    assign col_addr = col_count_reg;

    always_comb begin
        pos_flags.interior   = (col_count_reg >= ADDR_W'(2)) &&
                               (row_count_reg >= sgm_pkg::ROW_W'(2));
        pos_flags.frame_last = (col_count_reg == col_last) && (row_count_reg == row_last);
    end

endmodule

`default_nettype wire

// ===== sv/sgm_window_datapath.sv =====
// 3x3 window, Sobel kernels and result register of the Sobel core.
// Depends on sgm_pkg; takes the line store read data from two sgm_ram instances.
`default_nettype none

module sgm_window_datapath #(
    parameter int MAX_LINE = 1024,
    localparam int ADDR_W = $clog2(MAX_LINE)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic [sgm_pkg::PIXEL_W-1:0]   in_pixel,
    input  wire logic [ADDR_W-1:0]             in_addr,
    input  wire sgm_pkg::pos_flags_t           in_flags,
    output logic                               in_ready,
    input  wire logic [sgm_pkg::PIXEL_W-1:0]   upper_rd,
    input  wire logic [sgm_pkg::PIXEL_W-1:0]   middle_rd,
    output logic                               wr_en,
    output logic      [ADDR_W-1:0]             wr_addr,
    output logic      [sgm_pkg::PIXEL_W-1:0]   upper_wdata,
    output logic      [sgm_pkg::PIXEL_W-1:0]   middle_wdata,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [sgm_pkg::PIXEL_W-1:0]   out_magnitude,
    output logic                               out_last
);

    localparam int PW = sgm_pkg::PIXEL_W;

    // Window columns x-2 (entries 0..2) and x-1 (entries 3..5), top to bottom.
    logic [PW-1:0] win_reg [6];
    logic [PW-1:0] win_next [6];

    logic                s1_valid_reg, s1_valid_next;
    logic [PW-1:0]       s1_pixel_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    sgm_pkg::pos_flags_t s1_flags_reg;

    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] out_mag_reg,   out_mag_next;
    logic          out_last_reg,  out_last_next;

    logic s1_adv;

    logic [sgm_pkg::SUM_W-1:0]         sum_right, sum_left, sum_bottom, sum_top;
    logic signed [sgm_pkg::GRAD_W-1:0] grad_x, grad_y;
    logic [sgm_pkg::SUM_W-1:0]         abs_x, abs_y;
    logic [sgm_pkg::MAG_W-1:0]         mag_sum;
    logic [PW-1:0]                     mag_sat;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    // Kernel sums: right/left columns for Gx, bottom/top rows for Gy.
    always_comb begin
        sum_right  = sgm_pkg::SUM_W'(upper_rd) + {1'b0, middle_rd, 1'b0}
                   + sgm_pkg::SUM_W'(s1_pixel_reg);
        sum_left   = sgm_pkg::SUM_W'(win_reg[0]) + {1'b0, win_reg[1], 1'b0}
                   + sgm_pkg::SUM_W'(win_reg[2]);
        sum_bottom = sgm_pkg::SUM_W'(win_reg[2]) + {1'b0, win_reg[5], 1'b0}
                   + sgm_pkg::SUM_W'(s1_pixel_reg);
        sum_top    = sgm_pkg::SUM_W'(win_reg[0]) + {1'b0, win_reg[3], 1'b0}
                   + sgm_pkg::SUM_W'(upper_rd);

        grad_x = signed'({1'b0, sum_right})  - signed'({1'b0, sum_left});
        grad_y = signed'({1'b0, sum_bottom}) - signed'({1'b0, sum_top});

        abs_x = grad_x[sgm_pkg::GRAD_W-1] ? sgm_pkg::SUM_W'(-grad_x)
                                          : sgm_pkg::SUM_W'(grad_x);
        abs_y = grad_y[sgm_pkg::GRAD_W-1] ? sgm_pkg::SUM_W'(-grad_y)
                                          : sgm_pkg::SUM_W'(grad_y);

        mag_sum = sgm_pkg::MAG_W'(abs_x) + sgm_pkg::MAG_W'(abs_y);
        mag_sat = (mag_sum > sgm_pkg::MAG_W'(sgm_pkg::MAG_MAX)) ? PW'(sgm_pkg::MAG_MAX)
                                                                : mag_sum[PW-1:0];
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_valid) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end

        for (int i = 0; i < 6; i++) begin
            win_next[i] = win_reg[i];
        end
        if (s1_adv) begin
            win_next[0] = win_reg[3];
            win_next[1] = win_reg[4];
            win_next[2] = win_reg[5];
            win_next[3] = upper_rd;
            win_next[4] = middle_rd;
            win_next[5] = s1_pixel_reg;
        end

        out_valid_next = out_valid_reg;
        out_mag_next   = out_mag_reg;
        out_last_next  = out_last_reg;
        if (s1_adv) begin
            // Border pixels still move the window but leave no result.
            out_valid_next = s1_flags_reg.interior;
            out_mag_next   = mag_sat;
            out_last_next  = s1_flags_reg.frame_last;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            s1_pixel_reg <= in_pixel;
            s1_addr_reg  <= in_addr;
            s1_flags_reg <= in_flags;
        end
        out_mag_reg  <= out_mag_next;
        out_last_reg <= out_last_next;
    end

    // The column moves down one row in both line stores.
    assign wr_en        = s1_adv;
    assign wr_addr      = s1_addr_reg;
    assign upper_wdata  = middle_rd;
    assign middle_wdata = s1_pixel_reg;

    assign out_valid     = out_valid_reg;
    assign out_magnitude = out_mag_reg;
    assign out_last      = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/sobel_gradient_magnitude_core.sv =====
// Sobel edge detector core: 3x3 window, L1 gradient magnitude saturated to 255.
// Pixels stream in raster order, one request per clock when the result side keeps up; a
// pixel is read from the two line stores (MAX_LINE entries each, registered read) in the
// cycle it is accepted, combined with the window and the Sobel kernels when the input
// register advances, and its result then sits in the output register. Border pixels
// produce no result; the last interior result of a frame carries tlast. Writing
// frame_width (index 0) or frame_height (index 1) restarts the frame; cfg_ready is always
// high, so make writes only while no request is in flight. The line stores need no clearing
// after reset, since rows 0 and 1 of every frame fill them before they are read. Depends on
// sgm_pkg, sgm_raster_ctrl, sgm_ram and sgm_window_datapath.
`default_nettype none

module sobel_gradient_magnitude_core #(
    parameter int MAX_LINE = 1024
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [7:0] pixel
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [7:0]                         m_tdata,   // [7:0] magnitude
    output logic                                    m_tlast,   // frame_last
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [sgm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [sgm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ADDR_W = $clog2(MAX_LINE);

    logic                        pix_accept;
    logic                        cfg_write;
    logic [ADDR_W-1:0]           col_addr;
    sgm_pkg::pos_flags_t         pos_flags;
    logic [sgm_pkg::PIXEL_W-1:0] upper_rd, middle_rd;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [sgm_pkg::PIXEL_W-1:0] upper_wdata, middle_wdata;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign pix_accept = s_tvalid && s_tready;

    sgm_raster_ctrl #(
        .MAX_LINE (MAX_LINE)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pix_accept (pix_accept),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .col_addr   (col_addr),
        .pos_flags  (pos_flags)
    );

    sgm_ram #(
        .DATA_W (sgm_pkg::PIXEL_W),
        .DEPTH  (MAX_LINE)
    ) u_upper_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (upper_wdata),
        .rd_en   (pix_accept),
        .rd_addr (col_addr),
        .rd_data (upper_rd)
    );

    sgm_ram #(
        .DATA_W (sgm_pkg::PIXEL_W),
        .DEPTH  (MAX_LINE)
    ) u_middle_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (middle_wdata),
        .rd_en   (pix_accept),
        .rd_addr (col_addr),
        .rd_data (middle_rd)
    );

    sgm_window_datapath #(
        .MAX_LINE (MAX_LINE)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (pix_accept),
        .in_pixel      (s_tdata),
        .in_addr       (col_addr),
        .in_flags      (pos_flags),
        .in_ready      (s_tready),
        .upper_rd      (upper_rd),
        .middle_rd     (middle_rd),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .upper_wdata   (upper_wdata),
        .middle_wdata  (middle_wdata),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_magnitude (m_tdata),
        .out_last      (m_tlast)
    );

endmodule

`default_nettype wire

// ===== sv/sgm_checker.sv =====
// Port-level checks for the Sobel gradient magnitude core, bound to its top level.
// Depends only on the top level's stream ports.
`default_nettype none

module sgm_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

    // With the output register free or draining, the core must take a new request.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled although the output side is free");

    // A fresh result can only come from an accepted request that passed through the input and output registers.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching request");

    // Nothing comes out in the cycle right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind sobel_gradient_magnitude_core sgm_checker u_sgm_checker (.*);

`default_nettype wire
